@@ design/stti_pkg.sv @@
// ----------------------------------------------------------------------------
// stti_pkg
// Shared widths and inter-module types of the sigmoid / tanh table
// interpolator.
// ----------------------------------------------------------------------------
package stti_pkg;

  localparam int X_W      = 17;   // argument, signed q4.12
  localparam int T_W      = 16;   // knot fraction, q0.16
  localparam int H_W      = 32;   // hermite basis value, signed q1.30
  localparam int HP_W     = 52;   // basis polynomial before rounding, q0.48
  localparam int Y_W      = 18;   // result field
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  localparam logic signed [X_W-1:0] X_EDGE_LO = -17'sd32768;
  localparam logic signed [X_W-1:0] X_EDGE_HI = 17'sd32768;

  // load enables of the basis pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // hermite basis values in q1.30
  typedef struct packed {
    logic signed [H_W-1:0] h00;
    logic signed [H_W-1:0] h10;
    logic signed [H_W-1:0] h01;
    logic signed [H_W-1:0] h11;
  } basis_t;

endpackage

@@ design/stti_rom.sv @@
// ----------------------------------------------------------------------------
// stti_rom
// Knot memory: values and spacing-scaled derivatives of sigmoid and tanh,
// split into even and odd banks so both neighbouring knots come out of one
// registered read.
// ----------------------------------------------------------------------------
module stti_rom #(
  parameter int TABLE_ENTRIES = 256,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rd_en_i,
  input  logic                              fn_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  idx_i,
  output logic signed [OUT_FRAC_BITS+1:0]   y0_o,
  output logic signed [OUT_FRAC_BITS+1:0]   y1_o,
  output logic signed [OUT_FRAC_BITS+1:0]   d0_o,
  output logic signed [OUT_FRAC_BITS+1:0]   d1_o
);

  localparam int    IdxW      = $clog2(TABLE_ENTRIES);
  localparam int    EntryW    = OUT_FRAC_BITS + 2;
  localparam int    WordW     = 2 * EntryW;
  localparam int    HalfDepth = (TABLE_ENTRIES + 1) / 2;
  localparam int    HalfAw    = $clog2(HalfDepth);
  localparam int    BankAw    = HalfAw + 1;
  localparam int    BankDepth = 1 << BankAw;
  localparam longint KnotLast = TABLE_ENTRIES - 1;
  localparam longint KnotHalf = KnotLast / 2;
  localparam longint One30    = longint'(1) <<< 30;
  localparam longint Half30   = longint'(1) <<< 29;

  function automatic longint rnd_shr(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // long division by shift and subtract, n >= 0 and d > 0
  function automatic longint udiv(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 61; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & longint'(1));
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | longint'(1);
      end
    end
    return q;
  endfunction

  // exp(-f) for f in [0, 1], q2.30
  function automatic longint exp_neg_frac(input longint f);
    longint sum;
    longint term;
    int     k;
    sum  = One30;
    term = One30;
    for (k = 1; k <= 20; k++) begin
      term = udiv(term * f, longint'(k) <<< 30);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  localparam longint E1 = exp_neg_frac(One30);

  // exp(-a) for a >= 0, q2.30
  function automatic longint exp_neg(input longint a);
    longint n;
    longint f;
    longint r;
    longint j;
    n  = a >>> 30;
    f  = a & (One30 - 1);
    r  = exp_neg_frac(f);
    for (j = 0; j < n; j++) begin
      r = (r * E1 + Half30) >>> 30;
    end
    return r;
  endfunction

  // sel: sigmoid value, tanh value, sigmoid slope, tanh slope
  function automatic longint knot_value(input int knot, input int sel);
    longint num;
    longint mag;
    longint a;
    longint e;
    longint den;
    longint s;
    longint e2;
    longint den2;
    longint th;
    longint ds;
    longint dt;
    longint res;
    logic   neg;
    num  = 16 * longint'(knot) - 8 * KnotLast;
    neg  = (num < 0);
    mag  = neg ? -num : num;
    a    = udiv((mag <<< 30) + KnotHalf, KnotLast);
    e    = exp_neg(a);
    den  = One30 + e;
    s    = neg ? udiv(e * One30 + (den >>> 1), den)
               : udiv(One30 * One30 + (den >>> 1), den);
    e2   = (e * e + Half30) >>> 30;
    den2 = One30 + e2;
    th   = udiv((One30 - e2) * One30 + (den2 >>> 1), den2);
    if (neg) begin
      th = -th;
    end
    ds = (s * (One30 - s) + Half30) >>> 30;
    dt = One30 - ((th * th + Half30) >>> 30);
    ds = udiv(ds * 16 + KnotHalf, KnotLast);
    dt = udiv(dt * 16 + KnotHalf, KnotLast);
    case (sel)
      0:       res = s;
      1:       res = th;
      2:       res = ds;
      default: res = dt;
    endcase
    return rnd_shr(res, 30 - OUT_FRAC_BITS);
  endfunction

  // word layout {slope, value}, address {fn, knot / 2}
  logic [WordW-1:0] even_rom [BankDepth];
  logic [WordW-1:0] odd_rom  [BankDepth];

  for (genvar a = 0; a < BankDepth; a++) begin : g_word
    localparam int     Fn  = a >> HalfAw;
    localparam int     Kn  = a & ((1 << HalfAw) - 1);
    localparam longint EvY = knot_value(2 * Kn, Fn);
    localparam longint EvD = knot_value(2 * Kn, 2 + Fn);
    localparam longint OdY = knot_value(2 * Kn + 1, Fn);
    localparam longint OdD = knot_value(2 * Kn + 1, 2 + Fn);
    assign even_rom[a] = {EntryW'(EvD), EntryW'(EvY)};
    assign odd_rom[a]  = {EntryW'(OdD), EntryW'(OdY)};
  end

  logic [IdxW-1:0]   idx_inc;
  logic [BankAw-1:0] even_addr;
  logic [BankAw-1:0] odd_addr;
  logic [WordW-1:0]  even_q;
  logic [WordW-1:0]  odd_q;
  logic              lsb_q;

  assign idx_inc   = idx_i + IdxW'(1);
  assign even_addr = {fn_i, HalfAw'(idx_inc >> 1)};
  assign odd_addr  = {fn_i, HalfAw'(idx_i >> 1)};

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      even_q <= even_rom[even_addr];
      odd_q  <= odd_rom[odd_addr];
      lsb_q  <= idx_i[0];
    end
  end

  assign y0_o = lsb_q ? $signed(odd_q[EntryW-1:0])      : $signed(even_q[EntryW-1:0]);
  assign y1_o = lsb_q ? $signed(even_q[EntryW-1:0])     : $signed(odd_q[EntryW-1:0]);
  assign d0_o = lsb_q ? $signed(odd_q[WordW-1:EntryW])  : $signed(even_q[WordW-1:EntryW]);
  assign d1_o = lsb_q ? $signed(even_q[WordW-1:EntryW]) : $signed(odd_q[WordW-1:EntryW]);

endmodule

@@ design/stti_basis.sv @@
// ----------------------------------------------------------------------------
// stti_basis
// Three-stage pipeline forming the cubic hermite basis values from the knot
// fraction: square, cube, then polynomials rounded to q1.30.
// ----------------------------------------------------------------------------
module stti_basis (
  input  logic                         clk_i,
  input  stti_pkg::stage_en_t          en_i,
  input  logic [stti_pkg::T_W-1:0]     t_i,
  output stti_pkg::basis_t             basis_o
);

  localparam int TW     = stti_pkg::T_W;
  localparam int HPW    = stti_pkg::HP_W;
  localparam int HW     = stti_pkg::H_W;
  localparam int BShift = 3 * TW - 30;

  localparam logic signed [HPW-1:0] One48 = HPW'(1) << (3 * TW);
  localparam logic signed [HPW-1:0] RndH  = HPW'(1) << (BShift - 1);

  logic [2*TW-1:0]  t2_q;
  logic [TW-1:0]    ta_q;
  logic [3*TW-1:0]  t3_q;
  logic [2*TW-1:0]  t2b_q;
  logic [TW-1:0]    tb_q;
  stti_pkg::basis_t basis_q;
  stti_pkg::basis_t basis_d;

  logic signed [HPW-1:0] t3_s;
  logic signed [HPW-1:0] t2s_s;
  logic signed [HPW-1:0] tsh_s;
  logic signed [HPW-1:0] h00_w;
  logic signed [HPW-1:0] h10_w;
  logic signed [HPW-1:0] h01_w;
  logic signed [HPW-1:0] h11_w;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      t2_q <= (2*TW)'(t_i) * (2*TW)'(t_i);
      ta_q <= t_i;
    end
    if (en_i.s3) begin
      t3_q  <= (3*TW)'(t2_q) * (3*TW)'(ta_q);
      t2b_q <= t2_q;
      tb_q  <= ta_q;
    end
    if (en_i.s4) begin
      basis_q <= basis_d;
    end
  end

  always_comb begin
    t3_s  = $signed(HPW'(t3_q));
    t2s_s = $signed(HPW'({t2b_q, {TW{1'b0}}}));
    tsh_s = $signed(HPW'({tb_q, {(2*TW){1'b0}}}));
    h00_w = (t3_s <<< 1) - t2s_s - (t2s_s <<< 1) + One48;
    h10_w = t3_s - (t2s_s <<< 1) + tsh_s;
    h01_w = t2s_s + (t2s_s <<< 1) - (t3_s <<< 1);
    h11_w = t3_s - t2s_s;
    basis_d.h00 = HW'((h00_w + RndH) >>> BShift);
    basis_d.h10 = HW'((h10_w + RndH) >>> BShift);
    basis_d.h01 = HW'((h01_w + RndH) >>> BShift);
    basis_d.h11 = HW'((h11_w + RndH) >>> BShift);
  end

  assign basis_o = basis_q;

endmodule

@@ design/sigmoid_tanh_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// sigmoid_tanh_table_interpolator
// Sigmoid or tanh per beat from knot tables over [-8, +8], linear or cubic
// hermite interpolation between neighbouring knots.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid / tready        tdata: x_in; tuser: command
//   m_axis   out  tvalid / tready        tdata: y_out; tuser: clamped
//   cfg      in   cfg_valid / cfg_ready  cfg_data: interp_mode
//
// one beat per cycle sustained while m_axis_tready holds; a result passes the
// knot memory read, the basis cube and the product stages before it is
// presented.
// reset clears the stage valid bits and interp_mode; the knot memory is
// constant and needs no fill.
// a stalled output holds the output register; bubbles in the six stages
// still take new beats until the pipe is full.
// ----------------------------------------------------------------------------
module sigmoid_tanh_table_interpolator #(
  parameter int TABLE_ENTRIES = 256,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [stti_pkg::S_DATA_W-1:0]   s_axis_tdata,   // [16:0] x_in
  input  logic                            s_axis_tuser,   // [0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [stti_pkg::M_DATA_W-1:0]   m_axis_tdata,   // [17:0] y_out
  output logic                            m_axis_tuser,   // [0] clamped
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i
);

  localparam int XW     = stti_pkg::X_W;
  localparam int TW     = stti_pkg::T_W;
  localparam int HW     = stti_pkg::H_W;
  localparam int YW     = stti_pkg::Y_W;
  localparam int IdxW   = $clog2(TABLE_ENTRIES);
  localparam int EntryW = OUT_FRAC_BITS + 2;
  localparam int DifW   = EntryW + 1;
  localparam int LinW   = DifW + TW + 1;
  localparam int PW     = HW + EntryW;
  localparam int AccW   = PW + 2;
  localparam int PosW   = TW + IdxW;

  localparam logic [PosW-1:0] KnotLast = PosW'(TABLE_ENTRIES - 1);
  localparam logic [IdxW-1:0] IdxMax   = IdxW'(TABLE_ENTRIES - 2);

  localparam logic signed [LinW-1:0] LinRnd = LinW'(1) << (TW - 1);
  localparam logic signed [AccW-1:0] AccRnd = AccW'(1) << 29;
  localparam logic signed [AccW-1:0] Lim    = AccW'(1) << OUT_FRAC_BITS;
  localparam logic signed [AccW-1:0] OutMax = AccW'(131071);
  localparam logic signed [AccW-1:0] OutMin = -AccW'(131072);
  localparam logic signed [AccW-1:0] SatHi  = (Lim > OutMax) ? OutMax : Lim;
  localparam logic signed [AccW-1:0] SatLo  = (-Lim < OutMin) ? OutMin : -Lim;

  // configuration
  logic mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // stage valids and load enables
  logic [6:1] v_q;
  logic [6:1] v_d;
  logic [7:1] stage_en;
  logic [5:0] v_in;

  always_comb begin
    stage_en[7] = m_axis_tready;
    for (int k = 6; k >= 1; k--) begin
      stage_en[k] = !v_q[k] || stage_en[k+1];
    end
    v_in = {v_q[5:1], s_axis_tvalid};
    for (int k = 1; k <= 6; k++) begin
      v_d[k] = stage_en[k] ? v_in[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = stage_en[1];

  // knot position
  logic signed [XW-1:0] x_s;
  logic [XW-1:0]        x_off;
  logic [PosW-1:0]      pos;
  logic [IdxW-1:0]      idx_raw;
  logic                 lo_edge;
  logic                 hi_edge;
  logic [IdxW-1:0]      idx_d;
  logic [TW-1:0]        t_d;

  assign x_s     = $signed(s_axis_tdata[XW-1:0]);
  assign lo_edge = (x_s <= stti_pkg::X_EDGE_LO);
  assign hi_edge = (x_s >= stti_pkg::X_EDGE_HI);
  assign x_off   = XW'(x_s - stti_pkg::X_EDGE_LO);
  assign pos     = PosW'(x_off[TW-1:0]) * KnotLast;
  assign idx_raw = pos[PosW-1:TW];

  always_comb begin
    priority if (lo_edge) begin
      idx_d = '0;
      t_d   = '0;
    end else if (hi_edge) begin
      idx_d = IdxMax;
      t_d   = '0;
    end else begin
      idx_d = (idx_raw > IdxMax) ? IdxMax : idx_raw;
      t_d   = pos[TW-1:0];
    end
  end

  // stage 1
  logic            fn_1_q;
  logic [IdxW-1:0] idx_1_q;
  logic [TW-1:0]   t_1_q;
  logic [5:1]      cl_q;
  logic [5:1]      hi_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      fn_1_q  <= s_axis_tuser;
      idx_1_q <= idx_d;
      t_1_q   <= t_d;
      cl_q[1] <= lo_edge || hi_edge;
      hi_q[1] <= hi_edge;
    end
    for (int k = 2; k <= 5; k++) begin
      if (stage_en[k]) begin
        cl_q[k] <= cl_q[k-1];
        hi_q[k] <= hi_q[k-1];
      end
    end
  end

  // stage 2: knot read and t squared
  logic signed [EntryW-1:0] rom_y0;
  logic signed [EntryW-1:0] rom_y1;
  logic signed [EntryW-1:0] rom_d0;
  logic signed [EntryW-1:0] rom_d1;
  stti_pkg::stage_en_t      basis_en;
  stti_pkg::basis_t         basis;

  stti_rom #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (stage_en[2]),
    .fn_i    (fn_1_q),
    .idx_i   (idx_1_q),
    .y0_o    (rom_y0),
    .y1_o    (rom_y1),
    .d0_o    (rom_d0),
    .d1_o    (rom_d1)
  );

  assign basis_en.s2 = stage_en[2];
  assign basis_en.s3 = stage_en[3];
  assign basis_en.s4 = stage_en[4];

  stti_basis u_basis (
    .clk_i   (clk_i),
    .en_i    (basis_en),
    .t_i     (t_1_q),
    .basis_o (basis)
  );

  logic [TW-1:0] t_2_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      t_2_q <= t_1_q;
    end
  end

  // stage 3: linear product
  logic signed [DifW-1:0]   dif_w;
  logic signed [LinW-1:0]   lin_q;
  logic signed [EntryW-1:0] y0_3_q;
  logic signed [EntryW-1:0] y1_3_q;
  logic signed [EntryW-1:0] d0_3_q;
  logic signed [EntryW-1:0] d1_3_q;

  assign dif_w = DifW'(rom_y1) - DifW'(rom_y0);

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      lin_q  <= LinW'($signed({1'b0, t_2_q})) * LinW'(dif_w);
      y0_3_q <= rom_y0;
      y1_3_q <= rom_y1;
      d0_3_q <= rom_d0;
      d1_3_q <= rom_d1;
    end
  end

  // stage 4: linear result, basis ready
  logic signed [DifW-1:0]   ylin_d;
  logic signed [DifW-1:0]   ylin_4_q;
  logic signed [EntryW-1:0] y0_4_q;
  logic signed [EntryW-1:0] y1_4_q;
  logic signed [EntryW-1:0] d0_4_q;
  logic signed [EntryW-1:0] d1_4_q;

  assign ylin_d = DifW'(y0_3_q) + DifW'((lin_q + LinRnd) >>> TW);

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      ylin_4_q <= ylin_d;
      y0_4_q   <= y0_3_q;
      y1_4_q   <= y1_3_q;
      d0_4_q   <= d0_3_q;
      d1_4_q   <= d1_3_q;
    end
  end

  // stage 5: hermite products
  logic signed [PW-1:0]     p0_q;
  logic signed [PW-1:0]     p1_q;
  logic signed [PW-1:0]     p2_q;
  logic signed [PW-1:0]     p3_q;
  logic signed [DifW-1:0]   ylin_5_q;
  logic signed [EntryW-1:0] y1_5_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      p0_q     <= PW'($signed(basis.h00)) * PW'(y0_4_q);
      p1_q     <= PW'($signed(basis.h10)) * PW'(d0_4_q);
      p2_q     <= PW'($signed(basis.h01)) * PW'(y1_4_q);
      p3_q     <= PW'($signed(basis.h11)) * PW'(d1_4_q);
      ylin_5_q <= ylin_4_q;
      y1_5_q   <= y1_4_q;
    end
  end

  // stage 6: sum, select, saturate into the output register
  logic signed [AccW-1:0] acc_w;
  logic signed [AccW-1:0] cub_w;
  logic signed [AccW-1:0] sel_w;
  logic signed [AccW-1:0] sat_w;
  logic [YW-1:0]          y_d;
  logic [YW-1:0]          y_q;
  logic                   cl_6_q;

  always_comb begin
    acc_w = AccW'(p0_q) + AccW'(p1_q) + AccW'(p2_q) + AccW'(p3_q);
    cub_w = (acc_w + AccRnd) >>> 30;
    priority if (hi_q[5]) begin
      sel_w = AccW'(y1_5_q);
    end else if (mode_q) begin
      sel_w = cub_w;
    end else begin
      sel_w = AccW'(ylin_5_q);
    end
    priority if (sel_w > SatHi) begin
      sat_w = SatHi;
    end else if (sel_w < SatLo) begin
      sat_w = SatLo;
    end else begin
      sat_w = sel_w;
    end
    y_d = sat_w[YW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      y_q    <= y_d;
      cl_6_q <= cl_q[5];
    end
  end

  assign m_axis_tvalid = v_q[6];
  assign m_axis_tdata  = {{(stti_pkg::M_DATA_W-YW){1'b0}}, y_q};
  assign m_axis_tuser  = cl_6_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |-> s_axis_tready)
    else $error("empty pipe refuses input");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !m_axis_tready) |-> !s_axis_tready)
    else $error("full stalled pipe takes input");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[1])
    else $error("accepted beat lost at stage one");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((AccW'($signed(y_q)) <= SatHi) && (AccW'($signed(y_q)) >= SatLo)))
    else $error("result outside saturation range");

endmodule
